// ----- rtl/i2p_pkg.sv -----
// Shared types, character codes and decode helpers for the infix to postfix converter.
// It depends on nothing and is used by i2p_ctrl, i2p_datapath and the top level.
package i2p_pkg;

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_expr;
  } i2p_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       run_last;
    logic       expr_done;
    logic       error_seen;
  } i2p_out_t;

  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_PAREN,
    ST_OPPOP,
    ST_FLUSH,
    ST_FINISH
  } i2p_state_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;
    logic push;
    logic pop;
    logic emit;
    logic emit_top;
    logic err_set;
    logic finish;
  } i2p_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [7:0] cur_char;
    logic       cur_last;
    logic [7:0] top_char;
    logic       stack_empty;
    logic       stack_full;
    logic       paren_none;
    logic       emit_ok;
    logic       finish_ok;
  } i2p_stat_t;

  // '(' and everything that is not an operator rank 0
  function automatic logic [1:0] op_prio(input logic [7:0] c);
    logic [1:0] p;
    case (c)
      CH_CARET:           p = 2'd3;
      CH_STAR, CH_SLASH:  p = 2'd2;
      CH_PLUS, CH_MINUS:  p = 2'd1;
      default:            p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic logic is_operand(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           ((c >= 8'h30) && (c <= 8'h39));
  endfunction

endpackage

// ----- rtl/i2p_ctrl.sv -----
// Sequencer of the infix to postfix converter: decodes the held character and
// steps the operator stack one pop a cycle while the output is not stalled. Depends on i2p_pkg.
module i2p_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               src_valid,
  output logic               src_stall,
  input  i2p_pkg::i2p_stat_t stat,
  output i2p_pkg::i2p_cmd_t  cmd
);
  import i2p_pkg::*;

  i2p_state_t state, state_next;
  i2p_state_t after_char;
  logic [1:0] cur_prio;
  logic [1:0] top_prio;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign cur_prio   = op_prio(stat.cur_char);
  assign top_prio   = op_prio(stat.top_char);
  assign after_char = stat.cur_last ? ST_FLUSH : ST_FINISH;

  always_comb begin
    cmd        = '0;
    state_next = state;
    src_stall  = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (src_valid) begin
          cmd.latch  = 1'b1;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (is_operand(stat.cur_char)) begin
          cmd.emit   = 1'b1;
          state_next = after_char;
        end else if (stat.cur_char == CH_LPAREN) begin
          if (stat.stack_full) begin
            cmd.err_set = 1'b1;
          end else begin
            cmd.push = 1'b1;
          end
          state_next = after_char;
        end else if (stat.cur_char == CH_RPAREN) begin
          // no '(' anywhere on the stack: error is known before any pop
          if (stat.paren_none) begin
            cmd.err_set = 1'b1;
          end
          state_next = stat.stack_empty ? after_char : ST_PAREN;
        end else if (cur_prio != 2'd0) begin
          // full stack with nothing to pop: the operator is dropped
          if (stat.stack_full && (top_prio < cur_prio)) begin
            cmd.err_set = 1'b1;
          end
          state_next = ST_OPPOP;
        end else begin
          state_next = after_char;
        end
      end
      ST_PAREN: begin
        if (stat.stack_empty) begin
          state_next = after_char;
        end else if (stat.top_char == CH_LPAREN) begin
          cmd.pop    = 1'b1;
          state_next = after_char;
        end else if (stat.emit_ok) begin
          cmd.emit     = 1'b1;
          cmd.emit_top = 1'b1;
          cmd.pop      = 1'b1;
        end
      end
      ST_OPPOP: begin
        if (!stat.stack_empty && (top_prio >= cur_prio)) begin
          if (stat.emit_ok) begin
            cmd.emit     = 1'b1;
            cmd.emit_top = 1'b1;
            cmd.pop      = 1'b1;
          end
        end else begin
          cmd.push   = !stat.stack_full;
          state_next = after_char;
        end
      end
      ST_FLUSH: begin
        if (stat.stack_empty) begin
          state_next = ST_FINISH;
        end else if (stat.top_char == CH_LPAREN) begin
          cmd.pop = 1'b1;
        end else if (stat.emit_ok) begin
          cmd.emit     = 1'b1;
          cmd.emit_top = 1'b1;
          cmd.pop      = 1'b1;
        end
      end
      ST_FINISH: begin
        if (stat.finish_ok) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/i2p_datapath.sv -----
// Datapath of the infix to postfix converter: held request, operator stack memory,
// bracket count, error flag, one-deep pending result and output register. Depends on i2p_pkg.
module i2p_datapath #(
  parameter int STACK_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  i2p_pkg::i2p_in_t   src_data,
  output logic               dst_valid,
  input  logic               dst_stall,
  output i2p_pkg::i2p_out_t  dst_data,
  input  i2p_pkg::i2p_cmd_t  cmd,
  output i2p_pkg::i2p_stat_t stat
);
  import i2p_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [7:0]    mem [STACK_DEPTH];
  logic [7:0]    top_q;
  logic [CW-1:0] count, count_next, count_m1;
  logic [CW-1:0] paren_cnt;
  logic [AW-1:0] rd_addr;
  i2p_in_t       cur;
  logic          error_flag;
  logic          pend_valid;
  logic [7:0]    pend_char;
  logic [7:0]    emit_char;
  logic          out_free;
  logic          end_clear;

  assign end_clear = cmd.finish && cur.end_of_expr;

  always_comb begin
    if (end_clear) begin
      count_next = '0;
    end else if (cmd.push) begin
      count_next = count + CW'(1);
    end else if (cmd.pop) begin
      count_next = count - CW'(1);
    end else begin
      count_next = count;
    end
  end

  // top of stack is read ahead from the next count, so it is ready each cycle
  assign count_m1 = count_next - CW'(1);
  assign rd_addr  = count_m1[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[count[AW-1:0]] <= cur.in_char;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      top_q <= cur.in_char;
    end else begin
      top_q <= mem[rd_addr];
    end
  end

  assign emit_char = cmd.emit_top ? top_q : cur.in_char;
  assign out_free  = !dst_valid || !dst_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      paren_cnt  <= '0;
      error_flag <= 1'b0;
      pend_valid <= 1'b0;
      dst_valid  <= 1'b0;
    end else begin
      count <= count_next;
      if (end_clear) begin
        paren_cnt <= '0;
      end else if (cmd.push && (cur.in_char == CH_LPAREN)) begin
        paren_cnt <= paren_cnt + CW'(1);
      end else if (cmd.pop && (top_q == CH_LPAREN)) begin
        paren_cnt <= paren_cnt - CW'(1);
      end
      if (cmd.err_set) begin
        error_flag <= 1'b1;
      end else if (end_clear) begin
        error_flag <= 1'b0;
      end
      // a held result stays until taken; emit or finish loads the pending one or an end marker
      dst_valid <= (dst_valid && dst_stall) || (cmd.emit && pend_valid) ||
                   (cmd.finish && (pend_valid || cur.end_of_expr));
      if (cmd.emit) begin
        pend_valid <= 1'b1;
      end
      if (cmd.finish) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cur <= src_data;
    end
    if (cmd.emit) begin
      pend_char <= emit_char;
      if (pend_valid) begin
        dst_data <= '{out_char: pend_char, char_valid: 1'b1, run_last: 1'b0,
                      expr_done: 1'b0, error_seen: error_flag};
      end
    end
    if (cmd.finish) begin
      if (pend_valid) begin
        dst_data <= '{out_char: pend_char, char_valid: 1'b1, run_last: 1'b1,
                      expr_done: cur.end_of_expr, error_seen: error_flag};
      end else if (cur.end_of_expr) begin
        // bare end marker
        dst_data <= '{out_char: 8'h00, char_valid: 1'b0, run_last: 1'b1,
                      expr_done: 1'b1, error_seen: error_flag};
      end
    end
  end

  assign stat.cur_char    = cur.in_char;
  assign stat.cur_last    = cur.end_of_expr;
  assign stat.top_char    = top_q;
  assign stat.stack_empty = (count == '0);
  assign stat.stack_full  = (count == CW'(STACK_DEPTH));
  assign stat.paren_none  = (paren_cnt == '0);
  assign stat.emit_ok     = !pend_valid || out_free;
  assign stat.finish_ok   = (!pend_valid && !cur.end_of_expr) || out_free;

endmodule

// ----- rtl/infix_to_postfix_converter_unit.sv -----
// Top level of the infix to postfix converter: controller plus datapath.
// Depends on i2p_pkg, i2p_ctrl and i2p_datapath.
//
//   channel  valid      stall      payload                     role
//   src      src_valid  src_stall  src_data (i2p_in_t)         infix character in
//   dst      dst_valid  dst_stall  dst_data (i2p_out_t)        postfix character out
//
// A request is taken in ST_IDLE and decoded in ST_DISPATCH; stack entries are popped one
// by one and ST_FINISH hands over the last result. An operator pops in ST_OPPOP and is
// then pushed if there is room, a ')' pops in ST_PAREN down to and including its '(', and
// an end pops every stacked entry in ST_FLUSH before ST_FINISH.
// Results are held one deep so that the last of a request can be marked; a stalled
// output holds the sequencer in its current step. Reset clears the stack count,
// bracket count, error flag and all valid flags; stack contents need no reset.
module infix_to_postfix_converter_unit #(
  parameter int STACK_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              src_valid,
  output logic              src_stall,
  input  i2p_pkg::i2p_in_t  src_data,
  output logic              dst_valid,
  input  logic              dst_stall,
  output i2p_pkg::i2p_out_t dst_data
);
  import i2p_pkg::*;

  i2p_cmd_t  cmd;
  i2p_stat_t stat;

  i2p_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  i2p_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .src_data  (src_data),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_data  (dst_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for infix_to_postfix_converter_unit: directed expressions, then
// random well-formed and broken expressions under several idle and stall mixes.
// Depends on i2p_pkg and the converter RTL; results are checked against a shadow stack.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2p_pkg::*;

  localparam int DEPTH       = 16;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 60;
  localparam logic [7:0] OP_SET [5] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET};

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      src_valid = 1'b0;
  logic      src_stall;
  i2p_in_t   src_data = '0;
  logic      dst_valid;
  logic      dst_stall = 1'b0;
  i2p_out_t  dst_data;

  // shadow of the operator stack and the sticky error
  logic [7:0]  shadow_ops [DEPTH];
  int unsigned shadow_count = 0;
  logic        shadow_err = 1'b0;

  i2p_out_t    expected_postfix [$];
  int unsigned accepted_items = 0;
  int unsigned failures = 0;
  int unsigned cycle_count = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;

  infix_to_postfix_converter_unit #(.STACK_DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_data  (dst_data)
  );

  always #5 clk = ~clk;

  function automatic logic is_operand_char(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9");
  endfunction

  function automatic int unsigned rank_of(input logic [7:0] c);
    case (c)
      CH_CARET:          return 3;
      CH_STAR, CH_SLASH: return 2;
      CH_PLUS, CH_MINUS: return 1;
      default:           return 0;
    endcase
  endfunction

  function automatic i2p_out_t postfix_char(input logic [7:0] c, input logic v);
    i2p_out_t r;
    r = '0;
    r.out_char = c;
    r.char_valid = v;
    return r;
  endfunction

  function automatic void push_op(input logic [7:0] c);
    if (shadow_count >= DEPTH) begin
      shadow_err = 1'b1;
    end else begin
      shadow_ops[shadow_count] = c;
      shadow_count++;
    end
  endfunction

  // work out every result one accepted request causes
  function automatic void predict_postfix(input logic [7:0] c, input logic last);
    i2p_out_t   run [$];
    i2p_out_t   r;
    logic       found;
    logic [7:0] top;
    found = 1'b0;
    if (is_operand_char(c)) begin
      run.push_back(postfix_char(c, 1'b1));
    end else if (c == CH_LPAREN) begin
      push_op(c);
    end else if (c == CH_RPAREN) begin
      while (shadow_count > 0 && !found) begin
        shadow_count--;
        top = shadow_ops[shadow_count];
        if (top == CH_LPAREN) found = 1'b1;
        else run.push_back(postfix_char(top, 1'b1));
      end
      if (!found) shadow_err = 1'b1;
    end else if (rank_of(c) != 0) begin
      while (shadow_count > 0 && rank_of(shadow_ops[shadow_count - 1]) >= rank_of(c)) begin
        shadow_count--;
        run.push_back(postfix_char(shadow_ops[shadow_count], 1'b1));
      end
      push_op(c);
    end
    if (last) begin
      while (shadow_count > 0) begin
        shadow_count--;
        top = shadow_ops[shadow_count];
        if (top != CH_LPAREN) run.push_back(postfix_char(top, 1'b1));
      end
      if (run.size() == 0) run.push_back(postfix_char(8'h00, 1'b0));
    end
    foreach (run[i]) begin
      r = run[i];
      r.error_seen = shadow_err;
      r.run_last = (i == run.size() - 1);
      r.expr_done = last && (i == run.size() - 1);
      expected_postfix.push_back(r);
    end
    if (last) begin
      shadow_count = 0;
      shadow_err = 1'b0;
    end
  endfunction

  task automatic send_char(input logic [7:0] c, input logic last);
    i2p_in_t req;
    req.in_char = c;
    req.end_of_expr = last;
    while ($urandom_range(0, 99) < idle_pct) begin
      src_valid <= 1'b0;
      @(posedge clk);
    end
    src_valid <= 1'b1;
    src_data <= req;
    do @(posedge clk); while (src_stall);
    predict_postfix(c, last);
    if (last || is_operand_char(c) || rank_of(c) != 0 || c == CH_LPAREN || c == CH_RPAREN)
      accepted_items++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // stray bytes are dropped; an end on its own gives the bare end marker
  task automatic test_ignored_and_bare_end();
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
  endtask

  task automatic test_precedence_and_brackets();
    send_text("a+Z*9^0/(z-A)");
  endtask

  // error stays set for the rest of the expression; the next expression, a lone ')', sets it anew
  task automatic test_unmatched_close();
    send_text("1+)b");
    send_text(")");
  endtask

  // sixteen entries fill the stack, the '*' is dropped
  task automatic test_overflow();
    send_text("(+(+(+(+(+(+(+(+*");
  endtask

  task automatic test_random_mix(input int idle, input int stall, input int unsigned quota);
    logic [7:0]  expr [$];
    int unsigned start;
    int unsigned nest;
    int unsigned max_nest;
    int unsigned open_odds;
    int unsigned terms;
    idle_pct = idle;
    stall_pct = stall;
    start = accepted_items;
    while (accepted_items - start < quota) begin
      expr.delete();
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) expr.push_back(8'($urandom_range(0, 255)));
      end else begin
        nest = 0;
        max_nest = ($urandom_range(0, 7) == 0) ? 18 : 4;
        open_odds = (max_nest > 4) ? 3 : 1;
        terms = ($urandom_range(0, 5) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 4);
        for (int t = 0; t < terms; t++) begin
          while (nest < max_nest && $urandom_range(0, 3) < open_odds) begin
            expr.push_back(CH_LPAREN);
            nest++;
          end
          case ($urandom_range(0, 2))
            0:       expr.push_back("a" + 8'($urandom_range(0, 25)));
            1:       expr.push_back("A" + 8'($urandom_range(0, 25)));
            default: expr.push_back("0" + 8'($urandom_range(0, 9)));
          endcase
          while (nest > 0 && $urandom_range(0, 2) == 0) begin
            expr.push_back(CH_RPAREN);
            nest--;
          end
          if (t + 1 < terms) expr.push_back(OP_SET[$urandom_range(0, 4)]);
        end
        while (nest > 0) begin
          expr.push_back(CH_RPAREN);
          nest--;
        end
        // broken requests: a stray byte, a lost character or an extra bracket
        if ($urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 2))
            0:       expr.insert($urandom_range(0, expr.size()), 8'($urandom_range(0, 255)));
            1:       expr.delete($urandom_range(0, expr.size() - 1));
            default: expr.insert($urandom_range(0, expr.size()), CH_RPAREN);
          endcase
        end
        if (expr.size() == 0) expr.push_back(8'($urandom_range(0, 255)));
      end
      foreach (expr[i]) send_char(expr[i], i == expr.size() - 1);
    end
  endtask

  always @(posedge clk) begin
    dst_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin : check_results
    i2p_out_t want;
    if (!rst && dst_valid && !dst_stall) begin
      if (expected_postfix.size() == 0) begin
        $error("unexpected result: out_char %h", dst_data.out_char);
        failures++;
      end else begin
        want = expected_postfix.pop_front();
        if (dst_data.out_char !== want.out_char) begin
          $error("out_char: expected %h, got %h", want.out_char, dst_data.out_char);
          failures++;
        end
        if (dst_data.char_valid !== want.char_valid) begin
          $error("char_valid: expected %b, got %b", want.char_valid, dst_data.char_valid);
          failures++;
        end
        if (dst_data.run_last !== want.run_last) begin
          $error("run_last: expected %b, got %b", want.run_last, dst_data.run_last);
          failures++;
        end
        if (dst_data.expr_done !== want.expr_done) begin
          $error("expr_done: expected %b, got %b", want.expr_done, dst_data.expr_done);
          failures++;
        end
        if (dst_data.error_seen !== want.error_seen) begin
          $error("error_seen: expected %b, got %b", want.error_seen, dst_data.error_seen);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_ignored_and_bare_end();
    test_precedence_and_brackets();
    test_unmatched_close();
    test_overflow();
    test_random_mix(0, 0, 60);
    test_random_mix(83, 0, 55);
    test_random_mix(0, 83, 55);
    test_random_mix(20, 20, 60);
    src_valid <= 1'b0;
    stall_pct = 0;
    while (expected_postfix.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (failures == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
